// ===== src/chws_pkg.sv =====
package chws_pkg;

  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int SQRT_STEPS = 32;
  localparam int TERM_CELLS = 6;

  // Divisors of the Horner steps, one pair per term cell. A sine divisor of zero
  // means the sine lane passes through that cell unchanged.
  localparam int COS_DIVS [TERM_CELLS] = '{132, 90, 56, 30, 12, 2};
  localparam int SIN_DIVS [TERM_CELLS] = '{110, 72, 42, 20, 6, 0};

  localparam logic [29:0] PI_OVER_4_Q30 = 30'd843314857;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] rad;
  } sqrt_lane_t;

  typedef struct packed {
    sqrt_lane_t r_lane;
    sqrt_lane_t z_lane;
    logic [31:0] v;
  } sqrt_bus_t;

  typedef struct packed {
    logic [29:0] a;
    logic [29:0] a2;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [2:0]  oct;
    logic [31:0] r;
    logic [14:0] z;
  } term_bus_t;

  // One result bit of a digit-by-digit square root.
  function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t l);
    sqrt_lane_t  o;
    logic [35:0] rem4;
    logic [35:0] trial;
    rem4  = {l.rem, l.rad[63:62]};
    trial = {2'b00, l.root, 2'b01};
    if (rem4 >= trial) begin
      o.rem  = 34'(rem4 - trial);
      o.root = {l.root[30:0], 1'b1};
    end else begin
      o.rem  = rem4[33:0];
      o.root = {l.root[30:0], 1'b0};
    end
    o.rad = {l.rad[61:0], 2'b00};
    return o;
  endfunction

endpackage

// ===== src/chws_sqrt_cell.sv =====
module chws_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  chws_pkg::sqrt_bus_t in_bus,
  output logic                out_valid,
  output chws_pkg::sqrt_bus_t out_bus
);

  chws_pkg::sqrt_bus_t bus_next;

  always_comb begin
    bus_next.r_lane = chws_pkg::sqrt_step(in_bus.r_lane);
    bus_next.z_lane = chws_pkg::sqrt_step(in_bus.z_lane);
    bus_next.v      = in_bus.v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bus <= bus_next;
    end
  end

endmodule

// ===== src/chws_term_cell.sv =====
module chws_term_cell #(
  parameter int COS_DIV = 2,
  parameter int SIN_DIV = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  chws_pkg::term_bus_t in_bus,
  output logic                out_valid,
  output chws_pkg::term_bus_t out_bus
);

  localparam int SD = (SIN_DIV == 0) ? 1 : SIN_DIV;
  localparam logic SIN_ON = (SIN_DIV != 0);
  localparam logic [31:0] MS = 32'((64'd1 << 32) / SD);
  localparam logic [31:0] MC = 32'((64'd1 << 32) / COS_DIV);

  chws_pkg::term_bus_t b1, b2;
  chws_pkg::term_bus_t out_next;
  logic        v1, v2;
  logic [29:0] ps1, pc1, ps2, pc2, qs2, qc2;
  logic [60:0] prod_s, prod_c;
  logic [61:0] mag_s, mag_c;
  logic [39:0] rs, rc;
  logic [29:0] qs, qc;

  assign prod_s = in_bus.a2 * in_bus.ts;
  assign prod_c = in_bus.a2 * in_bus.tc;
  assign mag_s  = ps1 * MS;
  assign mag_c  = pc1 * MC;

  // The reciprocal estimate is low by at most one; the remainder fixes it.
  always_comb begin
    rs = 40'(ps2) - 40'(qs2) * 40'(SD);
    rc = 40'(pc2) - 40'(qc2) * 40'(COS_DIV);
    qs = qs2 + 30'(rs >= 40'(SD));
    qc = qc2 + 30'(rc >= 40'(COS_DIV));
  end

  always_comb begin
    out_next    = b2;
    out_next.tc = chws_pkg::Q30_ONE - 31'(qc);
    if (SIN_ON) begin
      out_next.ts = chws_pkg::Q30_ONE - 31'(qs);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1  <= in_bus;
      ps1 <= prod_s[59:30];
      pc1 <= prod_c[59:30];
      b2  <= b1;
      ps2 <= ps1;
      pc2 <= pc1;
      qs2 <= mag_s[61:32];
      qc2 <= mag_c[61:32];
      out_bus <= out_next;
    end
  end

endmodule

// ===== src/cosine_hemisphere_sample_warp_unit.sv =====
// Cosine-weighted hemisphere warp: each (u_sample, v_sample) item becomes one
// direction (dir_x, dir_y signed Q1.15; dir_z Q0.15), density proportional to cos(theta).
// The block is fully pipelined and takes one item per cycle while out_ready is high;
// it is built from the 32 square-root cells (one root bit each) and the six Horner
// term cells of the sine/cosine series.
// Any stall on the output holds the whole pipeline, and in_ready follows it.
module cosine_hemisphere_sample_warp_unit #(
  parameter int FRACTION_BITS = chws_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] u_sample,
  input  logic [15:0] v_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic [14:0] dir_z
);

  localparam logic [31:0] SAMPLE_MASK = 32'hFFFF_FFFF >> (32 - FRACTION_BITS);
  localparam int SHIFT = 32 - FRACTION_BITS;

  logic en;
  assign en = ~out_valid | out_ready;
  assign in_ready = en;

  // Widened samples.
  logic [31:0] u_w, v_w;
  logic        vw;
  always_ff @(posedge clk) begin
    if (rst) begin
      vw <= 1'b0;
    end else if (en) begin
      vw <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      u_w <= (32'(u_sample) & SAMPLE_MASK) << SHIFT;
      v_w <= (32'(v_sample) & SAMPLE_MASK) << SHIFT;
    end
  end

  // Square-root chain: r = sqrt(u), z = sqrt(1 - u).
  chws_pkg::sqrt_bus_t sbus [chws_pkg::SQRT_STEPS+1];
  logic                sval [chws_pkg::SQRT_STEPS+1];
  logic [32:0]         w_rest;

  assign w_rest = 33'h1_0000_0000 - 33'(u_w);
  always_comb begin
    sbus[0].r_lane.rem  = '0;
    sbus[0].r_lane.root = '0;
    sbus[0].r_lane.rad  = {u_w, 32'h0};
    sbus[0].z_lane.rem  = '0;
    sbus[0].z_lane.root = '0;
    sbus[0].z_lane.rad  = 64'(w_rest) << 28;
    sbus[0].v           = v_w;
  end
  assign sval[0] = vw;

  for (genvar g = 0; g < chws_pkg::SQRT_STEPS; g++) begin : g_sqrt
    chws_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(sval[g]), .in_bus(sbus[g]),
      .out_valid(sval[g+1]), .out_bus(sbus[g+1])
    );
  end

  // Octant reduction and angle.
  logic [31:0] v_s;
  logic [2:0]  oct_s;
  logic [29:0] f_s;
  logic [59:0] ang_prod;
  logic [31:0] zq_s;
  logic [32:0] z_round;
  logic [14:0] z_sat;

  assign v_s   = sbus[chws_pkg::SQRT_STEPS].v;
  assign oct_s = v_s[31:29];
  assign f_s   = oct_s[0] ? (30'h2000_0000 - {1'b0, v_s[28:0]}) : {1'b0, v_s[28:0]};
  assign ang_prod = f_s * chws_pkg::PI_OVER_4_Q30;
  assign zq_s  = sbus[chws_pkg::SQRT_STEPS].z_lane.root;
  assign z_round = (33'(zq_s) + 33'h4000) >> 15;
  assign z_sat = (z_round > 33'd32767) ? 15'h7FFF : z_round[14:0];

  logic        va;
  logic [29:0] a_a;
  logic [2:0]  oct_a;
  logic [31:0] r_a;
  logic [14:0] z_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= sval[chws_pkg::SQRT_STEPS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_a   <= ang_prod[58:29];
      oct_a <= oct_s;
      r_a   <= sbus[chws_pkg::SQRT_STEPS].r_lane.root;
      z_a   <= z_sat;
    end
  end

  // Angle squared, start of the series.
  logic [59:0]         a_sq;
  chws_pkg::term_bus_t tbus [chws_pkg::TERM_CELLS+1];
  logic                tval [chws_pkg::TERM_CELLS+1];
  assign a_sq = a_a * a_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      tval[0] <= 1'b0;
    end else if (en) begin
      tval[0] <= va;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tbus[0].a   <= a_a;
      tbus[0].a2  <= a_sq[59:30];
      tbus[0].ts  <= chws_pkg::Q30_ONE;
      tbus[0].tc  <= chws_pkg::Q30_ONE;
      tbus[0].oct <= oct_a;
      tbus[0].r   <= r_a;
      tbus[0].z   <= z_a;
    end
  end

  for (genvar g = 0; g < chws_pkg::TERM_CELLS; g++) begin : g_term
    chws_term_cell #(
      .COS_DIV(chws_pkg::COS_DIVS[g]),
      .SIN_DIV(chws_pkg::SIN_DIVS[g])
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(tval[g]), .in_bus(tbus[g]),
      .out_valid(tval[g+1]), .out_bus(tbus[g+1])
    );
  end

  // Finish sine, fold the octant back.
  chws_pkg::term_bus_t tl;
  logic [60:0] sin_prod;
  logic [30:0] sin_v, cos_v;
  logic        swap;
  assign tl = tbus[chws_pkg::TERM_CELLS];
  assign sin_prod = tl.a * tl.ts;
  assign sin_v = 31'(sin_prod[60:30]);
  assign cos_v = tl.tc;
  assign swap = tl.oct[0] ^ tl.oct[1];

  logic        vm;
  logic [30:0] cm_m, sm_m;
  logic        cneg_m, sneg_m;
  logic [31:0] r_m;
  logic [14:0] z_m;
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= tval[chws_pkg::TERM_CELLS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cm_m   <= swap ? sin_v : cos_v;
      sm_m   <= swap ? cos_v : sin_v;
      cneg_m <= tl.oct[1] ^ tl.oct[2];
      sneg_m <= tl.oct[2];
      r_m    <= tl.r;
      z_m    <= tl.z;
    end
  end

  // Radius scaling.
  logic        vp;
  logic [62:0] px_p, py_p;
  logic        cneg_p, sneg_p;
  logic [14:0] z_p;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vm;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px_p   <= r_m * cm_m;
      py_p   <= r_m * sm_m;
      cneg_p <= cneg_m;
      sneg_p <= sneg_m;
      z_p    <= z_m;
    end
  end

  logic [63:0] x_round, y_round;
  logic [15:0] x_mag, y_mag;
  assign x_round = 64'(px_p) + 64'h4000_0000_0000;
  assign y_round = 64'(py_p) + 64'h4000_0000_0000;
  assign x_mag = (x_round[63:47] > 17'd32767) ? 16'h7FFF : x_round[62:47];
  assign y_mag = (y_round[63:47] > 17'd32767) ? 16'h7FFF : y_round[62:47];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vp;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dir_x <= cneg_p ? (16'h0 - x_mag) : x_mag;
      dir_y <= sneg_p ? (16'h0 - y_mag) : y_mag;
      dir_z <= z_p;
    end
  end

endmodule

// ===== tb/chws_checker.sv =====
`timescale 1ns / 100ps

module chws_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [15:0]       u_sample,
  input  logic [15:0]       v_sample,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic [14:0]       dir_z,
  output int                fail_count,
  output int                pending,
  output int                dir_count
);

  localparam int FRAC = chws_pkg::FRACTION_BITS_DEFAULT;
  localparam logic [63:0] PI4 = 64'd843314857;
  localparam logic [63:0] ONE30 = 64'd1 << 30;
  localparam logic [63:0] SPAN = 64'd1 << 29;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] z;
  } dir_t;

  dir_t dir_queue[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [15:0] to_q15(input logic [63:0] r, input logic [63:0] m,
                                         input logic neg);
    logic [63:0] p;
    p = (r * m + (64'd1 << 46)) >> 47;
    if (p > 32767) p = 32767;
    return neg ? 16'(-p) : p[15:0];
  endfunction

  function automatic dir_t warp_dir(input logic [15:0] us, input logic [15:0] vs);
    logic [31:0] u, v;
    logic [63:0] r, f, a, a2, t, s, c, cm, sm, zq, zr;
    logic [2:0]  oct;
    logic        cneg, sneg;
    dir_t        d;
    u = 32'(us) << (32 - FRAC);
    v = 32'(vs) << (32 - FRAC);
    r = int_sqrt({u, 32'd0});
    oct = v[31:29];
    f = 64'(v[28:0]);
    if (oct[0]) f = SPAN - f;
    a = (f * PI4) >> 29;
    a2 = q30_mul(a, a);
    t = ONE30 - a2 / 110;
    t = ONE30 - q30_mul(a2, t) / 72;
    t = ONE30 - q30_mul(a2, t) / 42;
    t = ONE30 - q30_mul(a2, t) / 20;
    t = ONE30 - q30_mul(a2, t) / 6;
    s = q30_mul(a, t);
    t = ONE30 - a2 / 132;
    t = ONE30 - q30_mul(a2, t) / 90;
    t = ONE30 - q30_mul(a2, t) / 56;
    t = ONE30 - q30_mul(a2, t) / 30;
    t = ONE30 - q30_mul(a2, t) / 12;
    c = ONE30 - q30_mul(a2, t) / 2;
    // Octants 1, 2, 5 and 6 swap the roles of sine and cosine.
    if (oct == 1 || oct == 2 || oct == 5 || oct == 6) begin
      cm = s;
      sm = c;
    end else begin
      cm = c;
      sm = s;
    end
    cneg = (oct >= 2 && oct <= 5);
    sneg = oct[2];
    zq = int_sqrt(((64'd1 << 32) - 64'(u)) << 28);
    zr = (zq + (64'd1 << 14)) >> 15;
    if (zr > 32767) zr = 32767;
    d.x = to_q15(r, cm, cneg);
    d.y = to_q15(r, sm, sneg);
    d.z = zr[14:0];
    return d;
  endfunction

  assign pending = dir_queue.size();

  always @(posedge clk) begin
    dir_t e;
    if (rst) begin
      fail_count <= 0;
      dir_count <= 0;
    end else begin
      if (in_valid && in_ready) dir_queue.push_back(warp_dir(u_sample, v_sample));
      if (out_valid && out_ready) begin
        dir_count <= dir_count + 1;
        if (dir_queue.size() == 0) begin
          $display("%0t: unexpected item x=%0d y=%0d z=%0d", $time, dir_x, dir_y, dir_z);
          fail_count <= fail_count + 1;
        end else begin
          e = dir_queue.pop_front();
          if (e.x !== dir_x || e.y !== dir_y || e.z !== dir_z) begin
            $display("%0t: expected x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d", $time,
                     $signed(e.x), $signed(e.y), e.z, dir_x, dir_y, dir_z);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_cosine_hemisphere_sample_warp_unit.sv =====
`timescale 1ns / 100ps

module tb_cosine_hemisphere_sample_warp_unit;

  localparam int RANDOM_ITEMS = 1330;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  logic [15:0] u_sample = 0;
  logic [15:0] v_sample = 0;
  logic in_ready, out_valid;
  logic signed [15:0] dir_x, dir_y;
  logic [14:0] dir_z;
  int fail_count, pending, dir_count;
  int sent = 0;
  bit quiet = 0;
  bit stimulus_done = 0;

  logic [15:0] seed_u [$];
  logic [15:0] seed_v [$];

  cosine_hemisphere_sample_warp_unit dut (.*);

  chws_checker checker_i (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  task automatic send_item(input logic [15:0] u, input logic [15:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    u_sample <= u;
    v_sample <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Receiver: one long hold-off early to fill the pipeline, then random stall bursts.
  initial begin
    int n;
    @(posedge clk iff !rst);
    repeat (100) @(posedge clk);
    out_ready <= 1;
    forever begin
      n = $urandom_range(1, 9);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
        out_ready <= 1;
      end else begin
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int k;
    logic [15:0] u, v;
    repeat (4) @(posedge clk);
    rst <= 0;
    // Extremes, zero radius, octant boundaries and near-one radius.
    seed_u = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h4000, 16'hFFFE,
               16'h7FFF, 16'h1234, 16'hFFFF, 16'hC000, 16'h0000, 16'hFFFF};
    seed_v = '{16'h0000, 16'h0000, 16'hFFFF, 16'h2000, 16'h2000, 16'h4000, 16'h6000,
               16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hFFFF, 16'h1FFF, 16'hFFFF,
               16'h5555, 16'hAAAA, 16'h1000, 16'h3000, 16'h8000, 16'hDFFF};
    foreach (seed_u[i]) send_item(seed_u[i], seed_v[i]);
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS - 200) quiet = 1;
      case ($urandom_range(0, 5))
        0: u = 16'($urandom_range(65500, 65535));
        1: u = 16'($urandom_range(0, 40));
        default: u = 16'($urandom);
      endcase
      v = 16'($urandom);
      send_item(u, v);
    end
    in_valid <= 0;
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    $display("Sent %0d samples including zero radius, near-one radius and octant edges;",
             sent);
    $display("checked %0d directions under random stalls and a long output hold-off.",
             dir_count);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
